/* src/csf_pkg.sv */
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types and constants for the CSV field splitter.
// ----------------------------------------------------------------------------
package csf_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_AFTERQ = 2'd2
    } quote_mode_t;

    typedef enum logic {
        ACT_DATA = 1'b0,
        ACT_EOR  = 1'b1
    } action_t;

    typedef struct packed {
        quote_mode_t quote_mode;
        logic        skip_blank;
        logic        row_finished;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        quote_mode:   MODE_PLAIN,
        skip_blank:   1'b0,
        row_finished: 1'b0
    };

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       field_end;
        logic       row_end;
    } parse_result_t;

endpackage

/* src/csf_decode.sv */
// ----------------------------------------------------------------------------
// csf_decode
// Per-byte parse step: current state and one beat in, next state and
// an optional result out. Purely combinational.
// ----------------------------------------------------------------------------
module csf_decode
(
    input  csf_pkg::parse_state_t  state,
    input  logic                   action,
    input  logic [7:0]             in_byte,
    output csf_pkg::parse_state_t  state_next,
    output csf_pkg::parse_result_t result
);

    logic blank;

    assign blank = ((in_byte >= csf_pkg::CH_TAB) && (in_byte <= csf_pkg::CH_CR))
                   || (in_byte == csf_pkg::CH_SPACE);

    always_comb
    begin
        state_next = state;
        result     = '{valid: 1'b0, out_byte: 8'h00, field_end: 1'b0, row_end: 1'b0};

        if (action == csf_pkg::ACT_EOR)
        begin
            state_next = csf_pkg::STATE_RESET;
            if (!state.row_finished)
            begin
                result = '{valid: 1'b1, out_byte: 8'h00, field_end: 1'b1, row_end: 1'b1};
            end
        end
        else if (state.row_finished)
        begin
            // bytes after a NUL are dropped until end of row
        end
        else if (in_byte == csf_pkg::CH_NUL)
        begin
            state_next = '{quote_mode: csf_pkg::MODE_PLAIN, skip_blank: 1'b0,
                           row_finished: 1'b1};
            result     = '{valid: 1'b1, out_byte: 8'h00, field_end: 1'b1, row_end: 1'b1};
        end
        else if (state.skip_blank && blank)
        begin
            // leading whitespace after a comma
        end
        else
        begin
            state_next.skip_blank = 1'b0;
            case (state.quote_mode)
                csf_pkg::MODE_QUOTED:
                begin
                    if (in_byte == csf_pkg::CH_QUOTE)
                    begin
                        state_next.quote_mode = csf_pkg::MODE_AFTERQ;
                    end
                    else
                    begin
                        result = '{valid: 1'b1, out_byte: in_byte, field_end: 1'b0,
                                   row_end: 1'b0};
                    end
                end
                csf_pkg::MODE_AFTERQ:
                begin
                    if (in_byte == csf_pkg::CH_QUOTE)
                    begin
                        // doubled quote: one literal quote
                        state_next.quote_mode = csf_pkg::MODE_QUOTED;
                        result = '{valid: 1'b1, out_byte: in_byte, field_end: 1'b0,
                                   row_end: 1'b0};
                    end
                    else if (in_byte == csf_pkg::CH_COMMA)
                    begin
                        state_next.quote_mode = csf_pkg::MODE_PLAIN;
                        state_next.skip_blank = 1'b1;
                        result = '{valid: 1'b1, out_byte: 8'h00, field_end: 1'b1,
                                   row_end: 1'b0};
                    end
                    else
                    begin
                        state_next.quote_mode = csf_pkg::MODE_PLAIN;
                        result = '{valid: 1'b1, out_byte: in_byte, field_end: 1'b0,
                                   row_end: 1'b0};
                    end
                end
                default:
                begin
                    // plain; the unused code behaves as plain too
                    state_next.quote_mode = csf_pkg::MODE_PLAIN;
                    if (in_byte == csf_pkg::CH_QUOTE)
                    begin
                        state_next.quote_mode = csf_pkg::MODE_QUOTED;
                    end
                    else if (in_byte == csf_pkg::CH_COMMA)
                    begin
                        state_next.skip_blank = 1'b1;
                        result = '{valid: 1'b1, out_byte: 8'h00, field_end: 1'b1,
                                   row_end: 1'b0};
                    end
                    else
                    begin
                        result = '{valid: 1'b1, out_byte: in_byte, field_end: 1'b0,
                                   row_end: 1'b0};
                    end
                end
            endcase
        end
    end

endmodule

/* src/csf_out_stage.sv */
// ----------------------------------------------------------------------------
// csf_out_stage
// Result register with valid/ready towards the receiver.
// ----------------------------------------------------------------------------
module csf_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  csf_pkg::parse_result_t result,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   field_end,
    output logic                   row_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       fe_reg;
    logic       re_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = (load && result.valid) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load && result.valid)
        begin
            byte_reg <= result.out_byte;
            fe_reg   <= result.field_end;
            re_reg   <= result.row_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign field_end = fe_reg;
    assign row_end   = re_reg;

endmodule

/* src/csv_field_splitter.sv */
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a CSV row, one byte per beat, into unquoted field bytes and
// field/row end markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per row byte (action = 0)
//   or an end-of-row beat (action = 1, in_byte ignored).
//   Output channel (out_valid/out_ready): zero or one result per input beat,
//   either a field byte (field_end = 0) or a field end (field_end = 1,
//   out_byte = 0), row_end marking the row's last field.
//   Path: a beat is captured in the input register and its result is
//   loaded from there into the result register, which drives out_valid.
//   Throughput: one beat per cycle while no held result blocks the input
//   register (see Stall), set by the state update in the decode step
//   between the two registers.
//   Reset: both registers empty, quote mode plain, no blank skipping, row
//   not finished.
//   Stall: a held result blocks the input register only if the beat there
//   produces a result; in_ready then drops until out_ready returns.
// ----------------------------------------------------------------------------
module csv_field_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       field_end,
    output logic       row_end
);

    // input register
    logic       iv_reg;
    logic       iv_next;
    logic       act_reg;
    logic [7:0] byte_reg;

    // parse state
    csf_pkg::parse_state_t  state_reg;
    csf_pkg::parse_state_t  state_next;
    csf_pkg::parse_result_t result;

    logic can_load;
    logic advance;
    logic in_fire;

    csf_decode u_decode
    (
        .state      (state_reg),
        .action     (act_reg),
        .in_byte    (byte_reg),
        .state_next (state_next),
        .result     (result)
    );

    // a beat leaves the input register when it makes no result or the
    // result register has room
    assign advance  = iv_reg && (!result.valid || can_load);
    assign in_ready = !iv_reg || advance;
    assign in_fire  = in_valid && in_ready;
    assign iv_next  = in_fire || (iv_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg    <= 1'b0;
            state_reg <= csf_pkg::STATE_RESET;
        end
        else
        begin
            iv_reg <= iv_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= action;
            byte_reg <= in_byte;
        end
    end

    csf_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .field_end (field_end),
        .row_end   (row_end)
    );

endmodule

/* src/csf_checker.sv */
// ----------------------------------------------------------------------------
// csf_checker
// Port-level checks for the CSV field splitter, bound to the top level.
// ----------------------------------------------------------------------------
module csf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       field_end,
    input logic       row_end
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(field_end) && $stable(row_end))
        else $error("stalled result changed");

    // row end only on a field end
    a_row_fe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_end |-> field_end)
        else $error("row_end without field_end");

    // field end carries no byte
    a_fe_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_end |-> out_byte == 8'h00)
        else $error("field end with non-zero byte");

    // a result out of an empty pipe comes from an earlier accepted input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input beat");

endmodule

bind csv_field_splitter csf_checker u_csf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .field_end (field_end),
    .row_end   (row_end)
);
